@@ rtl/ecsd_pkg.sv @@
// ecsd_pkg: shared types and constants for the edge sort/dedup block.
// No dependencies.
package ecsd_pkg;

    localparam int unsigned CfgIdxBits = 1;
    localparam logic [CfgIdxBits-1:0] RegDirected   = 1'b0;
    localparam logic [CfgIdxBits-1:0] RegHasWeights = 1'b1;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SWAP_WA,
        ST_SWAP_WB,
        ST_EMIT_RD,
        ST_EMIT_WAIT,
        ST_EMIT_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic store_edge;   // write accepted edge at fill count
        logic scan_rd;      // compare finished: advance j or start the next pass
        logic wr_a;         // write swapped entry into j
        logic wr_b;         // write swapped entry into j+1
        logic emit_rd;      // read entry at emit index and the final entry
        logic emit_next;    // advance emit index
        logic emit_load;    // latch output register
        logic clear_set;    // end of set
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_last;      // accepted edge carries last mark
        logic less;         // entry j+1 < entry j
        logic pass_end;     // j+1 is last pair of this pass
        logic pass_clean;   // no swap in this pass
        logic final_pass;   // this pass compares only entries 0 and 1
        logic trivial;      // fewer than two stored edges
        logic empty;        // no stored edges
        logic emit_end;     // emit index at last entry
        logic dup;          // current entry's endpoints equal previous emitted
    } t_sts;

endpackage

@@ rtl/ecsd_ram.sv @@
// ecsd_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
module ecsd_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/ecsd_datapath.sv @@
// ecsd_datapath: edge store (two RAM copies for a two-port read), bubble sort
// compare/swap, dedup and output register. Depends on ecsd_pkg, ecsd_ram.
module ecsd_datapath #(
    parameter int unsigned MAX_EDGES   = 64,
    parameter int unsigned ID_BITS     = 32,
    parameter int unsigned WEIGHT_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ecsd_pkg::t_cmd         i_cmd,
    output ecsd_pkg::t_sts         o_sts,
    input  logic                   i_directed,
    input  logic                   i_has_weights,
    input  logic [ID_BITS-1:0]     i_src,
    input  logic [ID_BITS-1:0]     i_dst,
    input  logic [WEIGHT_BITS-1:0] i_weight,
    input  logic                   i_last,
    output logic [ID_BITS-1:0]     o_src,
    output logic [ID_BITS-1:0]     o_dst,
    output logic [WEIGHT_BITS-1:0] o_weight,
    output logic                   o_last,
    output logic                   o_overflow
);
    localparam int unsigned AW = $clog2(MAX_EDGES);
    localparam int unsigned CW = $clog2(MAX_EDGES + 1);
    localparam int unsigned EW = 2 * ID_BITS + WEIGHT_BITS;

    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic [AW-1:0] r_j, n_j;
    logic [AW-1:0] r_lim, n_lim;     // last j+1 index of current pass
    logic          r_swapped, n_swapped;
    logic [AW-1:0] r_e, n_e;
    logic          r_have_prev, n_have_prev;
    logic [ID_BITS-1:0] r_ps, r_pd;
    logic [ID_BITS-1:0] r_os, r_od;
    logic [WEIGHT_BITS-1:0] r_ow;
    logic          r_ol, r_oo;
    logic [EW-1:0] r_ea, r_eb;

    logic [ID_BITS-1:0] w_u, w_v;
    logic [EW-1:0]      w_ent, rd_a, rd_b, w_wdata;
    logic [AW-1:0]      w_waddr, w_raddr_a, w_raddr_b, w_jp1, w_last_idx;
    logic               w_we;
    logic [ID_BITS-1:0] a_s, a_d, b_s, b_d;

    assign w_jp1 = r_j + AW'(1);
    assign w_last_idx = AW'(r_count - CW'(1));
    assign w_u = (!i_directed && i_src > i_dst) ? i_dst : i_src;
    assign w_v = (!i_directed && i_src > i_dst) ? i_src : i_dst;
    assign w_ent = {w_u, w_v, i_weight};

    always_comb begin
        w_we = 1'b0;
        w_waddr = r_count[AW-1:0];
        w_wdata = w_ent;
        if (i_cmd.store_edge) begin
            w_we = (r_count < CW'(MAX_EDGES));
        end else if (i_cmd.wr_a) begin
            w_we = 1'b1;
            w_waddr = r_j;
            w_wdata = r_eb;
        end else if (i_cmd.wr_b) begin
            w_we = 1'b1;
            w_waddr = w_jp1;
            w_wdata = r_ea;
        end
    end

    // During emit, port b watches the final sorted entry: an item is the last
    // of the run when its endpoints match that entry.
    assign w_raddr_a = i_cmd.emit_rd ? r_e : r_j;
    assign w_raddr_b = i_cmd.emit_rd ? w_last_idx : w_jp1;

    ecsd_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_ram_a (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr_a), .o_rdata(rd_a));
    ecsd_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_ram_b (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr_b), .o_rdata(rd_b));

    assign a_s = rd_a[EW-1 -: ID_BITS];
    assign a_d = rd_a[WEIGHT_BITS +: ID_BITS];
    assign b_s = rd_b[EW-1 -: ID_BITS];
    assign b_d = rd_b[WEIGHT_BITS +: ID_BITS];

    always_comb begin
        o_sts.is_last    = i_last;
        o_sts.less       = (b_s < a_s) || (b_s == a_s && b_d < a_d);
        o_sts.pass_end   = (w_jp1 == r_lim);
        o_sts.pass_clean = !r_swapped;
        o_sts.final_pass = (r_lim == AW'(1));
        o_sts.trivial    = (r_count < CW'(2));
        o_sts.empty      = (r_count == '0);
        o_sts.emit_end   = (CW'(r_e) == r_count - CW'(1));
        o_sts.dup        = r_have_prev && a_s == r_ps && a_d == r_pd;
    end

    always_comb begin
        n_count = r_count;
        n_ovf = r_ovf;
        n_j = r_j;
        n_lim = r_lim;
        n_swapped = r_swapped;
        n_e = r_e;
        n_have_prev = r_have_prev;
        if (i_cmd.store_edge) begin
            if (r_count < CW'(MAX_EDGES)) begin
                n_count = r_count + CW'(1);
            end else begin
                n_ovf = 1'b1;
            end
            n_j = '0;
            n_swapped = 1'b0;
            n_e = '0;
            n_have_prev = 1'b0;
            if (i_last) begin
                if (r_count < CW'(MAX_EDGES)) begin
                    n_lim = r_count[AW-1:0];
                end else begin
                    n_lim = AW'(MAX_EDGES - 1);
                end
            end
        end
        if (i_cmd.wr_a) begin
            n_swapped = 1'b1;
        end
        if (i_cmd.scan_rd) begin
            // scan_rd marks "compare finished, move on"
            if (w_jp1 == r_lim) begin
                n_j = '0;
                n_swapped = 1'b0;
                n_lim = r_lim - AW'(1);
            end else begin
                n_j = w_jp1;
            end
        end
        if (i_cmd.emit_load) begin
            n_have_prev = 1'b1;
        end
        if (i_cmd.emit_next) begin
            n_e = r_e + AW'(1);
        end
        if (i_cmd.clear_set) begin
            n_count = '0;
            n_ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf <= 1'b0;
            r_j <= '0;
            r_lim <= '0;
            r_swapped <= 1'b0;
            r_e <= '0;
            r_have_prev <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf <= n_ovf;
            r_j <= n_j;
            r_lim <= n_lim;
            r_swapped <= n_swapped;
            r_e <= n_e;
            r_have_prev <= n_have_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_sts.less) begin
            r_ea <= rd_a;
            r_eb <= rd_b;
        end
        if (i_cmd.emit_load) begin
            r_ps <= a_s;
            r_pd <= a_d;
            r_os <= a_s;
            r_od <= a_d;
            r_ow <= i_has_weights ? rd_a[WEIGHT_BITS-1:0] : '0;
            r_ol <= (a_s == b_s) && (a_d == b_d);
            r_oo <= r_ovf;
        end
    end

    assign o_src = r_os;
    assign o_dst = r_od;
    assign o_weight = r_ow;
    assign o_last = r_ol;
    assign o_overflow = r_oo;
endmodule

@@ rtl/ecsd_ctrl.sv @@
// ecsd_ctrl: sequencer for load, bubble-sort passes and deduplicated emit.
// Depends on ecsd_pkg.
module ecsd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  ecsd_pkg::t_sts i_sts,
    output ecsd_pkg::t_cmd o_cmd
);
    ecsd_pkg::t_state r_state, n_state;
    logic r_ov, n_ov;

    always_comb begin
        n_state = r_state;
        n_ov = r_ov;
        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end
        case (r_state)
            ecsd_pkg::ST_LOAD: begin
                if (i_in_valid && i_sts.is_last) begin
                    n_state = ecsd_pkg::ST_SCAN_RD;
                end
            end
            ecsd_pkg::ST_SCAN_RD: begin
                if (i_sts.empty) begin
                    n_state = ecsd_pkg::ST_LOAD;
                end else if (i_sts.trivial) begin
                    n_state = ecsd_pkg::ST_EMIT_RD;
                end else begin
                    n_state = ecsd_pkg::ST_SCAN_CMP;
                end
            end
            ecsd_pkg::ST_SCAN_CMP: begin
                if (i_sts.less) begin
                    n_state = ecsd_pkg::ST_SWAP_WA;
                end else if (i_sts.pass_end && (i_sts.pass_clean || i_sts.final_pass)) begin
                    n_state = ecsd_pkg::ST_EMIT_RD;
                end else begin
                    n_state = ecsd_pkg::ST_SCAN_RD;
                end
            end
            ecsd_pkg::ST_SWAP_WA: n_state = ecsd_pkg::ST_SWAP_WB;
            ecsd_pkg::ST_SWAP_WB: begin
                // a swap that closes the final pass also ends the sort
                if (i_sts.pass_end && i_sts.final_pass) begin
                    n_state = ecsd_pkg::ST_EMIT_RD;
                end else begin
                    n_state = ecsd_pkg::ST_SCAN_RD;
                end
            end
            ecsd_pkg::ST_EMIT_RD: n_state = ecsd_pkg::ST_EMIT_WAIT;
            ecsd_pkg::ST_EMIT_WAIT: n_state = ecsd_pkg::ST_EMIT_OUT;
            ecsd_pkg::ST_EMIT_OUT: begin
                if (i_sts.dup) begin
                    n_state = i_sts.emit_end ? ecsd_pkg::ST_LOAD : ecsd_pkg::ST_EMIT_RD;
                end else if (!r_ov || i_out_ready) begin
                    n_ov = 1'b1;
                    n_state = i_sts.emit_end ? ecsd_pkg::ST_LOAD : ecsd_pkg::ST_EMIT_RD;
                end
            end
            default: n_state = ecsd_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = (r_state == ecsd_pkg::ST_LOAD);
        o_out_valid = r_ov;
        case (r_state)
            ecsd_pkg::ST_LOAD: o_cmd.store_edge = i_in_valid;
            ecsd_pkg::ST_SCAN_RD: o_cmd.clear_set = i_sts.empty;
            ecsd_pkg::ST_SCAN_CMP: begin
                o_cmd.scan_rd = !i_sts.less;
            end
            ecsd_pkg::ST_SWAP_WA: o_cmd.wr_a = 1'b1;
            ecsd_pkg::ST_SWAP_WB: begin
                o_cmd.wr_b = 1'b1;
                o_cmd.scan_rd = 1'b1;
            end
            ecsd_pkg::ST_EMIT_RD: o_cmd.emit_rd = 1'b1;
            ecsd_pkg::ST_EMIT_WAIT: o_cmd.emit_rd = 1'b1;
            ecsd_pkg::ST_EMIT_OUT: begin
                o_cmd.emit_rd = 1'b1;
                if (i_sts.dup || !r_ov || i_out_ready) begin
                    o_cmd.emit_next = 1'b1;
                    o_cmd.emit_load = !i_sts.dup;
                    o_cmd.clear_set = i_sts.emit_end;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ecsd_pkg::ST_LOAD;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov <= n_ov;
        end
    end

    a_store_only_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.store_edge |-> r_state == ecsd_pkg::ST_LOAD) else $error("store outside load");
    a_swap_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr_a |=> o_cmd.wr_b) else $error("swap half done");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_out_ready) |=> r_ov) else $error("output lost");
endmodule

@@ rtl/edge_canonical_sort_dedup_top.sv @@
// Edge list sort/dedup top: edges load one per cycle while s_axis_tready is high.
// After the last edge, an in-place bubble sort runs over the N stored edges (read,
// compare, write back on a swap); pass k has N-k compares, at most N-1 passes,
// and a pass without swaps ends the sort. Emit reads, waits, then outputs or drops
// each stored edge and may stall on the output; input stays blocked until the final
// stored edge is emitted or dropped as a duplicate. Reset (sync, active low) empties
// the set and clears configuration. Depends on ecsd_pkg, ecsd_ctrl, ecsd_datapath.
module edge_canonical_sort_dedup_top #(
    parameter int unsigned MAX_EDGES   = 64,
    parameter int unsigned ID_BITS     = 32,
    parameter int unsigned WEIGHT_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // tdata: src_id, dst_id, weight (low to high)
    input  logic [((2*ID_BITS+WEIGHT_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic s_axis_tlast,          // last_edge
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // tdata: out_src, out_dst, out_weight (low to high)
    output logic [((2*ID_BITS+WEIGHT_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic m_axis_tlast,          // out_last
    output logic m_axis_tuser,          // overflow
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic [ecsd_pkg::CfgIdxBits-1:0] i_cfg_index,
    input  logic i_cfg_data
);
    localparam int unsigned DW = ((2*ID_BITS+WEIGHT_BITS+7)/8)*8;
    localparam int unsigned PW = 2*ID_BITS + WEIGHT_BITS;

    ecsd_pkg::t_cmd w_cmd;
    ecsd_pkg::t_sts w_sts;
    logic r_directed, r_has_weights;
    logic [ID_BITS-1:0] w_os, w_od;
    logic [WEIGHT_BITS-1:0] w_ow;

    // Config registers, always writable.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_directed <= 1'b0;
            r_has_weights <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ecsd_pkg::RegDirected:   r_directed <= i_cfg_data;
                ecsd_pkg::RegHasWeights: r_has_weights <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ecsd_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_sts(w_sts), .o_cmd(w_cmd));

    ecsd_datapath #(.MAX_EDGES(MAX_EDGES), .ID_BITS(ID_BITS),
                    .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_directed(r_directed), .i_has_weights(r_has_weights),
        .i_src(s_axis_tdata[ID_BITS-1:0]),
        .i_dst(s_axis_tdata[2*ID_BITS-1:ID_BITS]),
        .i_weight(s_axis_tdata[PW-1:2*ID_BITS]),
        .i_last(s_axis_tlast),
        .o_src(w_os), .o_dst(w_od), .o_weight(w_ow),
        .o_last(m_axis_tlast), .o_overflow(m_axis_tuser));

    assign m_axis_tdata = DW'({w_ow, w_od, w_os});
endmodule
